// File: hdl/bbc_pkg.sv
// Shared types, codes and helpers for the bytecode compiler.
// No dependencies; imported by the controller, the top level and the checker.
package bbc_pkg;

  // Item operations
  localparam logic [1:0] OP_FEED = 2'd0;
  localparam logic [1:0] OP_END  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CLOSE = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;
  localparam logic [1:0] ST_OPEN  = 2'd3;

  // Instruction opcodes
  localparam logic [2:0] OPC_HALT = 3'd0;
  localparam logic [2:0] OPC_ADD  = 3'd1;
  localparam logic [2:0] OPC_LOAD = 3'd2;
  localparam logic [2:0] OPC_OMA  = 3'd3;
  localparam logic [2:0] OPC_IO   = 3'd4;
  localparam logic [2:0] OPC_JMP  = 3'd5;

  // Source command characters
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_OPEN  = 8'h5b;
  localparam logic [7:0] CH_CLOSE = 8'h5d;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S32_NEG1 = -32'sd1;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] arg;
    logic signed [31:0] shift;
  } instr_t;

  // 32-bit signed add, clamped at the range limits
  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add32 = s[32] ? S32_MIN : S32_MAX;
    end else begin
      sat_add32 = s[31:0];
    end
  endfunction

endpackage

// File: hdl/bbc_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// No dependencies; holds the instruction store and the bracket stack.
module bbc_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/bbc_ctrl.sv
// Compiler sequencer: decodes each beat, read-modify-writes the instruction RAM
// and bracket stack, and walks closed loop bodies. Depends on bbc_pkg.
module bbc_ctrl #(
  parameter int MEM_DEPTH = 4096,
  localparam int AW = $clog2(MEM_DEPTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [7:0]         in_source_byte,
  input  logic [11:0]        in_read_address,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [11:0]        out_instr_count,
  output bbc_pkg::instr_t    out_entry,
  output logic               im_we,
  output logic [AW-1:0]      im_waddr,
  output bbc_pkg::instr_t    im_wdata,
  output logic [AW-1:0]      im_raddr,
  input  bbc_pkg::instr_t    im_rdata,
  output logic               st_we,
  output logic [AW-1:0]      st_waddr,
  output logic [AW-1:0]      st_wdata,
  output logic [AW-1:0]      st_raddr,
  input  logic [AW-1:0]      st_rdata
);
  import bbc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_FIXB, S_S1_RD, S_S1_EV, S_S2_RD, S_S2_EV,
    S_LD_RD, S_LD_EV, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [AW:0]        depth_r, depth_nxt;
  logic [1:0]         err_r, err_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [7:0]         ch_r, ch_nxt;
  logic [11:0]        addr_r, addr_nxt;
  logic [AW-1:0]      beg_r, beg_nxt, end_r, end_nxt, i_r, i_nxt, w_r, w_nxt;
  logic signed [31:0] sh_r, sh_nxt, self_r, self_nxt;
  logic               ok_r, ok_nxt;
  instr_t             res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [11:0]        out_count_r, out_count_nxt;
  instr_t             out_entry_r, out_entry_nxt;

  logic               cm_en;
  logic [AW-1:0]      cm_pos;
  logic [AW:0]        cm_p1;
  logic signed [31:0] delta, sh_new, self_new;
  logic               prev_ok, last;

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_instr_count = out_count_r;
  assign out_entry       = out_entry_r;
  assign st_raddr        = AW'(depth_r - 1'b1);

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    depth_nxt      = depth_r;
    err_nxt        = err_r;
    op_nxt         = op_r;
    ch_nxt         = ch_r;
    addr_nxt       = addr_r;
    beg_nxt        = beg_r;
    end_nxt        = end_r;
    i_nxt          = i_r;
    w_nxt          = w_r;
    sh_nxt         = sh_r;
    self_nxt       = self_r;
    ok_nxt         = ok_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_entry_nxt  = out_entry_r;
    im_we          = 1'b0;
    im_waddr       = '0;
    im_wdata       = '0;
    im_raddr       = '0;
    st_we          = 1'b0;
    st_waddr       = depth_r[AW-1:0];
    st_wdata       = pos_r;
    cm_en          = 1'b0;
    cm_pos         = pos_r;
    delta          = (ch_r == CH_MINUS || ch_r == CH_LT) ? S32_NEG1 : 32'sd1;
    prev_ok        = 1'b0;
    sh_new         = sat_add32(sh_r, im_rdata.shift);
    self_new       = (sh_new == 32'sd0) ? sat_add32(self_r, im_rdata.arg) : self_r;
    last           = (i_r == end_r - 1'b1);

    unique case (state_r)
      S_IDLE: begin
        im_raddr = (in_operation == OP_READ) ? AW'(in_read_address) : pos_r - 1'b1;
        if (in_valid) begin
          op_nxt    = in_operation;
          ch_nxt    = in_source_byte;
          addr_nxt  = in_read_address;
          res_nxt   = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (op_r)
          OP_FEED: begin
            if (err_r == ST_OK) begin
              case (ch_r) inside
                CH_PLUS, CH_MINUS: begin
                  prev_ok = (pos_r != '0) &&
                            (im_rdata.opcode == OPC_ADD || im_rdata.opcode == OPC_LOAD);
                  im_we = 1'b1;
                  cm_en = 1'b1;
                  if (prev_ok) begin
                    im_waddr = pos_r - 1'b1;
                    im_wdata = '{im_rdata.opcode, sat_add32(im_rdata.arg, delta),
                                 im_rdata.shift};
                    cm_pos   = pos_r - 1'b1;
                  end else begin
                    im_waddr = pos_r;
                    im_wdata = '{OPC_ADD, delta, 32'sd0};
                  end
                end
                CH_LT, CH_GT: begin
                  prev_ok = (pos_r != '0) && im_rdata.opcode == OPC_ADD &&
                            im_rdata.arg == 32'sd0;
                  im_we = 1'b1;
                  cm_en = 1'b1;
                  if (prev_ok) begin
                    im_waddr = pos_r - 1'b1;
                    im_wdata = '{OPC_ADD, im_rdata.arg, sat_add32(im_rdata.shift, delta)};
                    cm_pos   = pos_r - 1'b1;
                  end else begin
                    im_waddr = pos_r;
                    im_wdata = '{OPC_ADD, 32'sd0, delta};
                  end
                end
                CH_COMMA, CH_DOT: begin
                  prev_ok = (pos_r != '0) && im_rdata.opcode == OPC_ADD &&
                            im_rdata.arg == 32'sd0;
                  im_we = 1'b1;
                  cm_en = 1'b1;
                  if (prev_ok) begin
                    im_waddr = pos_r - 1'b1;
                    im_wdata = '{OPC_IO, (ch_r == CH_DOT) ? 32'sd1 : 32'sd0,
                                 im_rdata.shift};
                    cm_pos   = pos_r - 1'b1;
                  end else begin
                    im_waddr = pos_r;
                    im_wdata = '{OPC_IO, (ch_r == CH_DOT) ? 32'sd1 : 32'sd0, 32'sd0};
                  end
                end
                CH_OPEN: begin
                  if (depth_r < (AW+1)'(MEM_DEPTH)) begin
                    im_we     = 1'b1;
                    im_waddr  = pos_r;
                    im_wdata  = '{OPC_JMP, 32'sd0, 32'sd0};
                    st_we     = 1'b1;
                    depth_nxt = depth_r + 1'b1;
                    cm_en     = 1'b1;
                  end
                end
                CH_CLOSE: begin
                  if (depth_r == '0) begin
                    err_nxt = ST_CLOSE;
                  end else begin
                    depth_nxt = depth_r - 1'b1;
                    if (st_rdata < pos_r) begin
                      im_we     = 1'b1;
                      im_waddr  = pos_r;
                      im_wdata  = '{OPC_JMP, 32'sd1, 32'(pos_r - st_rdata)};
                      beg_nxt   = st_rdata;
                      end_nxt   = pos_r;
                      state_nxt = S_FIXB;
                    end
                  end
                end
                default: ;
              endcase
            end
          end
          OP_END: begin
            if (err_r == ST_OK) begin
              if (depth_r != '0) begin
                err_nxt = ST_OPEN;
              end else begin
                im_we    = 1'b1;
                im_waddr = pos_r;
                im_wdata = '{OPC_HALT, 32'sd0, 32'sd0};
              end
            end
          end
          OP_READ: begin
            if ({20'd0, addr_r} < 32'(MEM_DEPTH)) begin
              res_nxt = im_rdata;
            end
          end
          default: ;
        endcase
      end
      S_FIXB: begin
        // patch the opening jump with its distance, then scan the body
        im_we    = 1'b1;
        im_waddr = beg_r;
        im_wdata = '{OPC_JMP, 32'sd0, 32'(end_r - beg_r)};
        i_nxt    = beg_r + 1'b1;
        sh_nxt   = 32'sd0;
        self_nxt = 32'sd0;
        ok_nxt   = 1'b1;
        if (beg_r + 1'b1 == end_r) begin
          cm_en  = 1'b1;
          cm_pos = end_r;
        end else begin
          state_nxt = S_S1_RD;
        end
      end
      S_S1_RD: begin
        im_raddr  = i_r;
        state_nxt = S_S1_EV;
      end
      S_S1_EV: begin
        sh_nxt   = sh_new;
        self_nxt = self_new;
        ok_nxt   = ok_r && (im_rdata.opcode == OPC_ADD);
        if (last) begin
          if (ok_nxt && sh_new == 32'sd0 && self_new == S32_NEG1) begin
            sh_nxt    = 32'sd0;
            w_nxt     = beg_r;
            i_nxt     = beg_r + 1'b1;
            state_nxt = S_S2_RD;
          end else begin
            cm_en  = 1'b1;
            cm_pos = end_r;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_S1_RD;
        end
      end
      S_S2_RD: begin
        im_raddr  = i_r;
        state_nxt = S_S2_EV;
      end
      S_S2_EV: begin
        // write slot trails the read index, so no entry is overwritten early
        sh_nxt = sh_new;
        if (sh_new != 32'sd0) begin
          im_we    = 1'b1;
          im_waddr = w_r;
          im_wdata = '{OPC_OMA, im_rdata.arg, sh_new};
          w_nxt    = w_r + 1'b1;
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = last ? S_LD_RD : S_S2_RD;
      end
      S_LD_RD: begin
        im_raddr  = beg_r - 1'b1;
        state_nxt = S_LD_EV;
      end
      S_LD_EV: begin
        im_we = 1'b1;
        cm_en = 1'b1;
        if (w_r == beg_r && beg_r != '0 && im_rdata.opcode == OPC_ADD &&
            im_rdata.arg == 32'sd0) begin
          im_waddr = beg_r - 1'b1;
          im_wdata = '{OPC_LOAD, im_rdata.arg, im_rdata.shift};
          cm_pos   = beg_r - 1'b1;
        end else begin
          im_waddr = w_r;
          im_wdata = '{OPC_LOAD, 32'sd0, 32'sd0};
          cm_pos   = w_r;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = err_r;
          out_count_nxt  = 12'(pos_r);
          out_entry_nxt  = res_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // advance the write position past the last emitted entry
    cm_p1 = {1'b0, cm_pos} + 1'b1;
    if (cm_en) begin
      pos_nxt   = cm_p1[AW-1:0];
      state_nxt = S_DONE;
      if (cm_p1 >= (AW+1)'(MEM_DEPTH - 1)) begin
        err_nxt = ST_OVF;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    ch_r          <= ch_nxt;
    addr_r        <= addr_nxt;
    beg_r         <= beg_nxt;
    end_r         <= end_nxt;
    i_r           <= i_nxt;
    w_r           <= w_nxt;
    sh_r          <= sh_nxt;
    self_r        <= self_nxt;
    ok_r          <= ok_nxt;
    res_r         <= res_nxt;
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
    out_entry_r   <= out_entry_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      depth_r     <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      depth_r     <= depth_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/bf_source_to_bytecode_compiler.sv
// Feed, end and read beats pass through an execute and a done state before
// the result is registered; the next beat waits until the sequencer is idle.
// A closing bracket walks its body once, and a second time for a clear loop.
// Throughput is set by the single-read-port instruction RAM and sequencer.
// Reset (rst_n, synchronous, active low) clears position, stack depth, status
// and the output valid flag; the RAMs hold no reset value and are not swept.
//
// Structure: bbc_ctrl sequences every beat; bbc_ram instances hold the
// instruction store (opcode, arg, shift) and the bracket stack. Depends on bbc_pkg.
// Each beat: present the read address on accept, modify the returned entry
// in the next cycle and write it back, then hold the result in the output
// register so the next beat can be taken while it waits.
module bf_source_to_bytecode_compiler #(
  parameter int MEM_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [7:0]         in_source_byte,
  input  logic [11:0]        in_read_address,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [11:0]        out_instr_count,
  output logic [2:0]         out_opcode,
  output logic signed [31:0] out_arg,
  output logic signed [31:0] out_shift_amount
);
  import bbc_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);

  logic          im_we, st_we;
  logic [AW-1:0] im_waddr, im_raddr, st_waddr, st_raddr, st_wdata, st_rdata;
  instr_t        im_wdata, im_rdata, out_entry;

  // Controller: decode, merge runs, match brackets, rewrite clear loops
  bbc_ctrl #(.MEM_DEPTH(MEM_DEPTH)) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_source_byte  (in_source_byte),
    .in_read_address (in_read_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_instr_count (out_instr_count),
    .out_entry       (out_entry),
    .im_we           (im_we),
    .im_waddr        (im_waddr),
    .im_wdata        (im_wdata),
    .im_raddr        (im_raddr),
    .im_rdata        (im_rdata),
    .st_we           (st_we),
    .st_waddr        (st_waddr),
    .st_wdata        (st_wdata),
    .st_raddr        (st_raddr),
    .st_rdata        (st_rdata)
  );

  // Instruction store: one entry per compiled instruction
  bbc_ram #(.DEPTH(MEM_DEPTH), .WIDTH($bits(instr_t))) u_imem (
    .clk   (clk),
    .we    (im_we),
    .waddr (im_waddr),
    .wdata (im_wdata),
    .raddr (im_raddr),
    .rdata (im_rdata)
  );

  // Bracket stack: positions of open jumps awaiting their match
  bbc_ram #(.DEPTH(MEM_DEPTH), .WIDTH(AW)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign out_opcode       = out_entry.opcode;
  assign out_arg          = out_entry.arg;
  assign out_shift_amount = out_entry.shift;

endmodule

// File: hdl/bbc_checker.sv
// Port-level checker for the bytecode compiler, bound to the top level.
// Depends on bf_source_to_bytecode_compiler port names and bbc_pkg status codes.
module bbc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_operation,
  input logic [7:0]         in_source_byte,
  input logic [11:0]        in_read_address,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic [11:0]        out_instr_count,
  input logic [2:0]         out_opcode,
  input logic signed [31:0] out_arg,
  input logic signed [31:0] out_shift_amount
);
  import bbc_pkg::*;

  logic        err_seen_r;
  logic [1:0]  last_status_r;
  logic [11:0] last_count_r;

  // Capture the first delivered error beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r    <= 1'b0;
      last_status_r <= ST_OK;
      last_count_r  <= 12'd0;
    end else if (out_valid && !out_stall && out_status != ST_OK && !err_seen_r) begin
      err_seen_r    <= 1'b1;
      last_status_r <= out_status;
      last_count_r  <= out_instr_count;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_instr_count) && $stable(out_opcode) && $stable(out_arg) &&
      $stable(out_shift_amount))
    else $error("stalled result beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  a_status_latched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && err_seen_r |-> out_status == last_status_r)
    else $error("error status changed before reset");

  a_count_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && err_seen_r |-> out_instr_count == last_count_r)
    else $error("write position moved after error");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind bf_source_to_bytecode_compiler bbc_checker u_bbc_checker (.*);

// File: test/tb_bf_source_to_bytecode_compiler.sv
// Self-checking testbench for bf_source_to_bytecode_compiler.
// Holds a scoreboard class with its own compiler predictor; depends on bbc_pkg and the RTL.
`timescale 1ns / 100ps

module tb_bf_source_to_bytecode_compiler;
  import bbc_pkg::*;

  localparam int DEPTH = 4096;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         status;
    logic [11:0]        count;
    logic [2:0]         opcode;
    logic signed [31:0] arg;
    logic signed [31:0] shift;
  } beat_result_t;

  // Scoreboard: a compiler predictor plus the queue of results it owes.
  class bytecode_scoreboard;
    logic [2:0]  opc_mem[DEPTH];
    int          arg_mem[DEPTH];
    int          shift_mem[DEPTH];
    int          open_pos[DEPTH];
    bit          written[DEPTH];
    int          wpos;
    int          depth;
    int          top_written;
    logic [1:0]  err;
    int          errors;
    int          checked;
    int          rewrites;
    beat_result_t owed[$];

    function new();
      wpos = 0;
      depth = 0;
      top_written = -1;
      err = ST_OK;
      errors = 0;
      checked = 0;
      rewrites = 0;
    endfunction

    function int clamp_add(int a, longint b);
      longint s;
      s = longint'(a) + b;
      if (s > 64'sd2147483647) return 32'sh7fff_ffff;
      if (s < -64'sd2147483648) return 32'sh8000_0000;
      return int'(s);
    endfunction

    function void put(int p, logic [2:0] opc, int a, int s);
      opc_mem[p] = opc;
      arg_mem[p] = a;
      shift_mem[p] = s;
      written[p] = 1'b1;
      if (p > top_written) top_written = p;
    endfunction

    // Fold into a preceding pure-shift ADD, else open a fresh entry.
    function int fold_shift(int pos, logic [2:0] opc);
      if (pos > 0 && opc_mem[pos-1] == OPC_ADD && arg_mem[pos-1] == 0) begin
        opc_mem[pos-1] = opc;
        return pos - 1;
      end
      put(pos, opc, 0, 0);
      return pos;
    endfunction

    function int bump_cell(int pos, int delta);
      int p;
      p = pos;
      if (pos > 0 && (opc_mem[pos-1] == OPC_ADD || opc_mem[pos-1] == OPC_LOAD)) p = pos - 1;
      else put(pos, OPC_ADD, 0, 0);
      arg_mem[p] = clamp_add(arg_mem[p], delta);
      return p;
    endfunction

    // Turn a decrement-by-one loop of plain ADDs into OMA entries and a LOAD.
    function int collapse_loop(int first, int last);
      int sh, self, w, a;
      sh = 0;
      self = 0;
      for (int i = first + 1; i < last; i++) begin
        if (opc_mem[i] != OPC_ADD) return last;
        sh = clamp_add(sh, shift_mem[i]);
        if (sh == 0) self = clamp_add(self, arg_mem[i]);
      end
      if (sh != 0 || self != -1) return last;
      rewrites++;
      sh = 0;
      w = first;
      for (int i = first + 1; i < last; i++) begin
        a = arg_mem[i];
        sh = clamp_add(sh, shift_mem[i]);
        if (sh != 0) begin
          put(w, OPC_OMA, a, sh);
          w++;
        end
      end
      return fold_shift(w, OPC_LOAD);
    endfunction

    function void compile_char(logic [7:0] ch);
      int pos, b;
      pos = wpos;
      if (pos >= DEPTH) return;
      case (ch)
        CH_PLUS:  pos = bump_cell(pos, 1);
        CH_MINUS: pos = bump_cell(pos, -1);
        CH_LT, CH_GT: begin
          pos = fold_shift(pos, OPC_ADD);
          shift_mem[pos] = clamp_add(shift_mem[pos], (ch == CH_LT) ? -1 : 1);
        end
        CH_OPEN: begin
          if (depth >= DEPTH) return;
          put(pos, OPC_JMP, 0, 0);
          open_pos[depth] = pos;
          depth++;
        end
        CH_CLOSE: begin
          if (depth == 0) begin
            err = ST_CLOSE;
            return;
          end
          depth--;
          b = open_pos[depth];
          if (b >= pos) return;
          put(pos, OPC_JMP, 1, pos - b);
          shift_mem[b] = pos - b;
          pos = collapse_loop(b, pos);
        end
        CH_COMMA, CH_DOT: begin
          pos = fold_shift(pos, OPC_IO);
          arg_mem[pos] = (ch == CH_DOT) ? 1 : 0;
        end
        default: return;
      endcase
      pos++;
      if (pos >= DEPTH - 1) err = ST_OVF;
      wpos = pos;
    endfunction

    // Note an accepted input beat and queue the result it must produce.
    function void record_beat(logic [1:0] op, logic [7:0] ch, logic [11:0] addr);
      beat_result_t r;
      r.opcode = '0;
      r.arg = '0;
      r.shift = '0;
      if (op == OP_FEED && err == ST_OK) begin
        compile_char(ch);
      end else if (op == OP_END && err == ST_OK) begin
        if (depth != 0) err = ST_OPEN;
        else put(wpos, OPC_HALT, 0, 0);
      end else if (op == OP_READ) begin
        r.opcode = opc_mem[addr];
        r.arg = arg_mem[addr];
        r.shift = shift_mem[addr];
      end
      r.status = err;
      r.count = wpos[11:0];
      owed.push_back(r);
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(beat_result_t got);
      beat_result_t e;
      if (owed.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = owed.pop_front();
      checked++;
      if (got.status !== e.status)
        report($sformatf("status got %0d want %0d", got.status, e.status));
      if (got.count !== e.count)
        report($sformatf("instr_count got %0d want %0d", got.count, e.count));
      if (got.opcode !== e.opcode)
        report($sformatf("opcode got %0d want %0d", got.opcode, e.opcode));
      if (got.arg !== e.arg)
        report($sformatf("arg got %0d want %0d", got.arg, e.arg));
      if (got.shift !== e.shift)
        report($sformatf("shift got %0d want %0d", got.shift, e.shift));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_operation = OP_FEED;
  logic [7:0]         in_source_byte = '0;
  logic [11:0]        in_read_address = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic [11:0]        out_instr_count;
  logic [2:0]         out_opcode;
  logic signed [31:0] out_arg;
  logic signed [31:0] out_shift_amount;

  bytecode_scoreboard sb = new();
  bit calm = 1'b0;       // set to run both sides without gaps or stalls
  int beats_sent = 0;
  int stall_left = 0;

  bf_source_to_bytecode_compiler dut (.*);

  always #4 clk = ~clk;

  function int draw_wait();
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  // Result side: check each accepted beat, then hold stall for a random count.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result('{out_status, out_instr_count, out_opcode, out_arg, out_shift_amount});
      stall_left = draw_wait();
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  // Drive one beat; valid stays high across back-to-back beats.
  task send(logic [1:0] op, logic [7:0] ch, logic [11:0] addr);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_source_byte <= (op == OP_FEED) ? ch : 8'($urandom_range(0, 255));
    in_read_address <= (op == OP_READ) ? addr : 12'($urandom_range(0, 4095));
    do @(posedge clk); while (in_stall);
    sb.record_beat(op, (op == OP_FEED) ? ch : in_source_byte,
                   (op == OP_READ) ? addr : in_read_address);
    beats_sent++;
  endtask

  task feed(logic [7:0] ch);
    send(OP_FEED, ch, '0);
  endtask

  // Read only entries that have been written since reset.
  task read_back();
    int a;
    if (sb.top_written < 0) return;
    a = $urandom_range(0, sb.top_written);
    if (!sb.written[a]) a = sb.top_written;
    send(OP_READ, '0, 12'(a));
  endtask

  function bit is_command(logic [7:0] b);
    return b == CH_PLUS || b == CH_MINUS || b == CH_LT || b == CH_GT ||
           b == CH_OPEN || b == CH_CLOSE || b == CH_COMMA || b == CH_DOT;
  endfunction

  // Move-and-add loop: [- >..> +..+ <..< ], sometimes spoiled so it stays a loop.
  task transfer_loop();
    int k, m;
    k = $urandom_range(1, 3);
    m = $urandom_range(1, 4);
    feed(CH_OPEN);
    feed(CH_MINUS);
    repeat (k) feed(CH_GT);
    repeat (m) feed($urandom_range(0, 3) == 0 ? CH_MINUS : CH_PLUS);
    if ($urandom_range(0, 2) == 0) begin
      feed(CH_GT);
      feed(CH_PLUS);
      feed(CH_LT);
    end
    repeat (k) feed(CH_LT);
    case ($urandom_range(0, 5))
      0: feed(CH_PLUS);
      1: feed(CH_DOT);
      2: feed(CH_GT);
      default: ;
    endcase
    if (sb.depth > 0) feed(CH_CLOSE);
  endtask

  task random_beat();
    logic [7:0] b;
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) feed($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
    else if (r < 22) feed($urandom_range(0, 1) ? CH_LT : CH_GT);
    else if (r < 28) feed($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
    else if (r < 36) feed(sb.depth < 6 ? CH_OPEN : CH_PLUS);
    else if (r < 44) feed(sb.depth > 0 ? CH_CLOSE : CH_MINUS);
    else if (r < 50) begin
      do b = 8'($urandom_range(0, 255)); while (is_command(b));
      feed(b);
    end
    else if (r < 60) transfer_loop();
    else if (r < 65) begin
      if (sb.depth == 0) send(OP_END, '0, '0);
      else feed(CH_CLOSE);
    end
    else if (r < 90) read_back();
    else if (r < 92) send(OP_UNUSED, '0, '0);
    else repeat ($urandom_range(3, 6)) feed(CH_PLUS);
  endtask

  initial begin
    int kind;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every command, noise extremes, simple and move loops, end, reads.
    calm = 1'b1;
    feed(CH_PLUS); feed(CH_MINUS); feed(CH_GT); feed(CH_LT);
    calm = 1'b0;
    feed(CH_DOT); feed(CH_COMMA); feed(8'h00); feed(8'hff);
    feed(CH_OPEN); feed(CH_MINUS); feed(CH_CLOSE);
    feed(CH_OPEN); feed(CH_CLOSE);
    feed(CH_OPEN); feed(CH_MINUS); feed(CH_GT); feed(CH_PLUS); feed(CH_LT); feed(CH_CLOSE);
    send(OP_END, '0, '0);
    send(OP_UNUSED, '0, '0);
    repeat (4) read_back();

    // Random programs; alternate stretches of full rate with gappy traffic.
    while (beats_sent < 1100) begin
      calm = ($urandom_range(0, 7) == 0);
      repeat (40) random_beat();
    end
    calm = 1'b0;
    while (sb.depth > 0) feed(CH_CLOSE);
    send(OP_END, '0, '0);

    // Grow the store toward higher addresses so reads reach them, then latch an error.
    kind = $urandom_range(0, 1);
    calm = 1'b1;
    while (sb.wpos < 2200 && beats_sent < 1450) begin
      feed($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
      if ($urandom_range(0, 15) == 0) read_back();
    end
    calm = 1'b0;
    if (kind == 0) feed(CH_CLOSE);
    else begin
      feed(CH_OPEN);
      send(OP_END, '0, '0);
    end
    // Latched: feeds and ends must change nothing, reads still answer.
    feed(CH_PLUS); feed(CH_OPEN); send(OP_END, '0, '0);
    repeat (20) read_back();
    in_valid <= 1'b0;

    for (int i = 0; i < 100000 && sb.owed.size() > 0; i++) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d beats, checked %0d results, %0d loops collapsed to multiply-add.",
             beats_sent, sb.checked, sb.rewrites);
    $display("Final position %0d, latched status %0d.", sb.wpos, sb.err);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d results outstanding", sb.owed.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
hdl/bbc_pkg.sv
hdl/bbc_ram.sv
hdl/bbc_ctrl.sv
hdl/bf_source_to_bytecode_compiler.sv
hdl/bbc_checker.sv
test/tb_bf_source_to_bytecode_compiler.sv
